### design/pvsd_pkg.sv
// Package for the prefix varint stream decoder: item types, lead-byte
// thresholds, length codes and the value masks of each compressed length.
// No dependencies.
package pvsd_pkg;

    // Lead-byte thresholds
    localparam logic [7:0] LEAD_TWO   = 8'h80;
    localparam logic [7:0] LEAD_THREE = 8'hC0;
    localparam logic [7:0] LEAD_FOUR  = 8'hE0;
    localparam logic [7:0] LEAD_FIVE  = 8'hF0;

    // Compressed lengths in bytes
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;
    localparam logic [2:0] LEN_FIVE  = 3'd5;

    // Raw low word length in 64-bit mode
    localparam logic [4:0] RAW_BYTES = 5'd4;

    // Value masks
    localparam logic [31:0] MASK_TWO   = 32'h0000_7FFF;
    localparam logic [31:0] MASK_THREE = 32'h003F_FFFF;
    localparam logic [31:0] MASK_FOUR  = 32'h1FFF_FFFF;

    // Action codes
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Status codes
    localparam logic STAT_DONE      = 1'b0;
    localparam logic STAT_TRUNCATED = 1'b1;

    // Format modes
    localparam logic MODE_32 = 1'b0;
    localparam logic MODE_64 = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] value_high;
        logic [31:0] value_low;
        logic [3:0]  bytes_used;
        logic        status;
    } out_item_t;

    // Compressed length picked by a lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] lead);
        logic [2:0] len;
        if (lead < LEAD_TWO)        len = LEN_ONE;
        else if (lead < LEAD_THREE) len = LEN_TWO;
        else if (lead < LEAD_FOUR)  len = LEN_THREE;
        else if (lead < LEAD_FIVE)  len = LEN_FOUR;
        else                        len = LEN_FIVE;
        return len;
    endfunction

    // Strip the length prefix bits from the collected compressed word
    function automatic logic [31:0] mask_value(input logic [31:0] v, input logic [2:0] len);
        logic [31:0] r;
        if (len == LEN_TWO)        r = v & MASK_TWO;
        else if (len == LEN_THREE) r = v & MASK_THREE;
        else if (len == LEN_FOUR)  r = v & MASK_FOUR;
        else                       r = v;
        return r;
    endfunction

endpackage

### design/pvsd_if.sv
// Channel interfaces of the prefix varint stream decoder: byte items in,
// result items out, and the format register write channel. No dependencies.
interface pvsd_byte_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface pvsd_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_high;
    logic [31:0] value_low;
    logic [3:0]  bytes_used;
    logic        status;

    modport source (output valid, output value_high, output value_low,
                    output bytes_used, output status, input ready);
    modport sink   (input valid, input value_high, input value_low,
                    input bytes_used, input status, output ready);
endinterface

interface pvsd_cfg_if;
    logic valid;
    logic ready;
    logic format_mode;

    modport source (output valid, output format_mode, input ready);
    modport sink   (input valid, input format_mode, output ready);
endinterface

### design/prefix_varint_stream_decoder_unit.sv
// Top level of the prefix varint stream decoder.
// Depends on pvsd_pkg and the channel interfaces in pvsd_if.sv.
//
// Usage:
//   bytes   - one item per stream byte; action 0 carries data_byte, action 1
//             marks the end of the buffer and flushes a truncated result.
//   results - one item per completed value (status 0) or per end of buffer
//             (status 1, zero values, bytes_used = bytes taken so far).
//   cfg     - writes format_mode (0: 32-bit value, 1: compressed high word
//             plus raw 32-bit low word). Always ready; write only while idle.
// Timing:
//   An accepted item sits in the input register. A byte that finishes a
//   value, or an end item, is decoded from there into the result register and
//   is offered on results from there. One byte is accepted per cycle while no
//   result waits on a stall, set by the single decode step between the registers.
// Reset clears the decode state, the format register and both valid flags.
// Stalls: while results is stalled, bytes that do not finish a value keep
//   flowing; a byte that would finish one waits in the input register, and
//   bytes.ready drops until the result register frees.
module prefix_varint_stream_decoder_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    pvsd_byte_if.sink            bytes,
    pvsd_result_if.source        results,
    pvsd_cfg_if.sink             cfg
);

    // Format register
    logic format_mode_reg;

    // Input register
    logic               in_valid_reg;
    pvsd_pkg::in_item_t in_item_reg;

    // Decode state
    logic [3:0]  byte_count_reg;
    logic [2:0]  clen_reg;
    logic [31:0] hacc_reg;
    logic [31:0] lacc_reg;

    // Result register
    logic                out_valid_reg;
    pvsd_pkg::out_item_t out_item_reg;

    // Decode logic
    logic                first_byte;
    logic                in_compressed;
    logic [2:0]          lead_len;
    logic [2:0]          clen_next;
    logic [31:0]         hacc_next;
    logic [31:0]         lacc_next;
    logic [3:0]          byte_count_next;
    logic [4:0]          need_bytes;
    logic                done;
    logic                emit;
    logic                out_free;
    logic                fire;
    logic [31:0]         value;
    pvsd_pkg::out_item_t out_item_next;

    assign first_byte    = (byte_count_reg == 4'd0) || (clen_reg == pvsd_pkg::LEN_NONE);
    assign in_compressed = {1'b0, byte_count_reg} < {2'b00, clen_reg};
    assign lead_len      = pvsd_pkg::lead_length(in_item_reg.data_byte);

    always_comb
    begin
        if (first_byte)
        begin
            clen_next       = lead_len;
            hacc_next       = (lead_len == pvsd_pkg::LEN_FIVE) ? 32'd0
                                                               : {24'd0, in_item_reg.data_byte};
            lacc_next       = 32'd0;
            byte_count_next = 4'd1;
        end
        else
        begin
            clen_next       = clen_reg;
            hacc_next       = in_compressed ? {hacc_reg[23:0], in_item_reg.data_byte} : hacc_reg;
            lacc_next       = in_compressed ? lacc_reg : {lacc_reg[23:0], in_item_reg.data_byte};
            byte_count_next = byte_count_reg + 4'd1;
        end
    end

    // Completion check: compressed part, plus the raw word in 64-bit mode
    assign need_bytes = (format_mode_reg == pvsd_pkg::MODE_64)
                        ? {2'b00, clen_next} + pvsd_pkg::RAW_BYTES
                        : {2'b00, clen_next};
    assign done  = {1'b0, byte_count_next} >= need_bytes;
    assign emit  = (in_item_reg.action == pvsd_pkg::ACT_END) || done;
    assign value = pvsd_pkg::mask_value(hacc_next, clen_next);

    // Result item
    always_comb
    begin
        if (in_item_reg.action == pvsd_pkg::ACT_END)
        begin
            out_item_next.value_high = 32'd0;
            out_item_next.value_low  = 32'd0;
            out_item_next.bytes_used = byte_count_reg;
            out_item_next.status     = pvsd_pkg::STAT_TRUNCATED;
        end
        else if (format_mode_reg == pvsd_pkg::MODE_64)
        begin
            out_item_next.value_high = value;
            out_item_next.value_low  = lacc_next;
            out_item_next.bytes_used = byte_count_next;
            out_item_next.status     = pvsd_pkg::STAT_DONE;
        end
        else
        begin
            out_item_next.value_high = 32'd0;
            out_item_next.value_low  = value;
            out_item_next.bytes_used = byte_count_next;
            out_item_next.status     = pvsd_pkg::STAT_DONE;
        end
    end

    // Handshakes
    assign out_free    = !out_valid_reg || results.ready;
    assign fire        = in_valid_reg && (!emit || out_free);
    assign bytes.ready = !in_valid_reg || fire;
    assign cfg.ready   = 1'b1;

    // Format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_mode_reg <= pvsd_pkg::MODE_32;
        else if (cfg.valid)
            format_mode_reg <= cfg.format_mode;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (bytes.ready)
            in_valid_reg <= bytes.valid;
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_item_reg.action    <= bytes.action;
            in_item_reg.data_byte <= bytes.data_byte;
        end
    end

    // Decode state: cleared when a result is loaded into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 4'd0;
            clen_reg       <= pvsd_pkg::LEN_NONE;
            hacc_reg       <= 32'd0;
            lacc_reg       <= 32'd0;
        end
        else if (fire)
        begin
            if (emit)
            begin
                byte_count_reg <= 4'd0;
                clen_reg       <= pvsd_pkg::LEN_NONE;
                hacc_reg       <= 32'd0;
                lacc_reg       <= 32'd0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                clen_reg       <= clen_next;
                hacc_reg       <= hacc_next;
                lacc_reg       <= lacc_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
            out_item_reg <= out_item_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.value_high = out_item_reg.value_high;
    assign results.value_low  = out_item_reg.value_low;
    assign results.bytes_used = out_item_reg.bytes_used;
    assign results.status     = out_item_reg.status;

    // Checks
    // a partial value never runs past its compressed part plus raw word
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < ({1'b0, clen_reg} + 4'd4) || clen_reg == pvsd_pkg::LEN_NONE)
        else $error("byte count beyond value length");

    // no byte is counted without a lead byte
    a_lead_first: assert property (@(posedge clk) disable iff (!rst_n)
        clen_reg == pvsd_pkg::LEN_NONE |-> byte_count_reg == 4'd0)
        else $error("bytes counted without a lead byte");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("stalled result changed");

    // truncated results carry zero values; completed ones use at least one byte
    a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_item_reg.status == pvsd_pkg::STAT_TRUNCATED &&
             out_item_reg.value_high == 32'd0 && out_item_reg.value_low == 32'd0) ||
            (out_item_reg.status == pvsd_pkg::STAT_DONE &&
             out_item_reg.bytes_used != 4'd0 && out_item_reg.bytes_used <= 4'd9))
        else $error("malformed result item");

    // a result is only loaded from an item in the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a source item");

endmodule
